// ===== hdl/positional_insert_delete_array_assert.svh =====
// Assertion macros for the positional insert/delete list checker.
// Both expect signals named clock and reset in the scope of use.
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_ASSERT_SVH

// Same-cycle implication.
`define PIDA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PIDA_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/pida_pkg.sv =====
// Shared types and constants for the positional insert/delete list.
// No dependencies; used by the interfaces, datapath, controller and checker.
package pida_pkg;

   localparam int WORD_W    = 32;
   localparam int POS_W     = 4;
   localparam int OP_W      = 3;
   localparam int STATUS_W  = 2;
   localparam int CNT_OUT_W = 5;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR   = 3'd0,
      OP_APPEND  = 3'd1,
      OP_DISPLAY = 3'd2,
      OP_INSERT  = 3'd3,
      OP_DELETE  = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_BADPOS = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   // Controller to datapath
   typedef struct packed {
      logic exec;       // run the request and load the result register
      logic disp_step;  // load the next displayed word
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic multi;      // more than one word stored
      logic step_last;  // display index points at the final word
   } stat_type;

endpackage

// ===== hdl/pida_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on pida_pkg for field widths.
interface pida_req_if;
   logic                                valid;
   logic                                ready;
   logic [pida_pkg::OP_W-1:0]           operation;
   logic [pida_pkg::POS_W-1:0]          position;
   logic signed [pida_pkg::WORD_W-1:0]  value;

   modport source (output valid, output operation, output position, output value,
                   input ready);
   modport sink   (input valid, input operation, input position, input value,
                   output ready);
endinterface

interface pida_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [pida_pkg::WORD_W-1:0]  data_out;
   logic [pida_pkg::STATUS_W-1:0]       status;
   logic [pida_pkg::CNT_OUT_W-1:0]      count_after;
   logic                                last;

   modport source (output valid, output data_out, output status, output count_after,
                   output last, input ready);
   modport sink   (input valid, input data_out, input status, input count_after,
                   input last, output ready);
endinterface

// ===== hdl/pida_dp.sv =====
// Datapath: register row of list words, word count, display index, result register.
// Depends on pida_pkg; driven by pida_ctrl through cmd_type.
module pida_dp #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pida_pkg::cmd_type                   cmd,
   input  logic [pida_pkg::OP_W-1:0]           operation,
   input  logic [pida_pkg::POS_W-1:0]          position,
   input  logic signed [pida_pkg::WORD_W-1:0]  value,
   output pida_pkg::stat_type                  stat,
   output logic signed [pida_pkg::WORD_W-1:0]  data_out,
   output logic [pida_pkg::STATUS_W-1:0]       status,
   output logic [pida_pkg::CNT_OUT_W-1:0]      count_after,
   output logic                                last
);

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int IW   = $clog2(DEPTH);
   localparam int CMPW = (CW > pida_pkg::POS_W) ? CW : pida_pkg::POS_W;

   logic signed [pida_pkg::WORD_W-1:0] entries_ff [DEPTH];
   logic signed [pida_pkg::WORD_W-1:0] entries_in [DEPTH];
   logic [CW-1:0]                      count_ff, count_in;
   logic [IW-1:0]                      idx_ff, idx_in;

   logic signed [pida_pkg::WORD_W-1:0] data_ff, data_in;
   pida_pkg::status_type               status_ff, status_in;
   logic [pida_pkg::CNT_OUT_W-1:0]     cnt_out_ff, cnt_out_in;
   logic                               last_ff, last_in;

   logic [CMPW-1:0]                    pos_ext, cnt_ext, ins_pos;
   logic                               full, empty, ins_en, del_en;
   logic [IW-1:0]                      rd_addr;
   logic signed [pida_pkg::WORD_W-1:0] rd_word;

   assign pos_ext = CMPW'(position);
   assign cnt_ext = CMPW'(count_ff);
   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);

   assign stat.multi     = (count_ff > CW'(1));
   assign stat.step_last = ((CW'(idx_ff) + CW'(1)) == count_ff);

   // Single read port: display index while streaming, else head or delete position
   always_comb begin
      if (cmd.disp_step) begin
         rd_addr = idx_ff;
      end else if (operation == pida_pkg::OP_DELETE) begin
         rd_addr = IW'(position);
      end else begin
         rd_addr = '0;
      end
   end
   assign rd_word = entries_ff[rd_addr];

   always_comb begin
      count_in   = count_ff;
      idx_in     = idx_ff;
      data_in    = '0;
      status_in  = pida_pkg::ST_OK;
      last_in    = 1'b1;
      ins_en     = 1'b0;
      ins_pos    = cnt_ext;
      del_en     = 1'b0;
      if (cmd.exec) begin
         unique case (operation)
            pida_pkg::OP_CLEAR: begin
               count_in = '0;
            end
            pida_pkg::OP_APPEND: begin
               if (full) begin
                  status_in = pida_pkg::ST_FULL;
               end else begin
                  ins_en = 1'b1;
               end
            end
            pida_pkg::OP_DISPLAY: begin
               if (empty) begin
                  status_in = pida_pkg::ST_EMPTY;
               end else begin
                  data_in = rd_word;
                  last_in = (count_ff == CW'(1));
                  idx_in  = IW'(1);
               end
            end
            pida_pkg::OP_INSERT: begin
               if (full) begin
                  status_in = pida_pkg::ST_FULL;
               end else if (pos_ext > cnt_ext) begin
                  status_in = pida_pkg::ST_BADPOS;
               end else begin
                  ins_en  = 1'b1;
                  ins_pos = pos_ext;
               end
            end
            pida_pkg::OP_DELETE: begin
               if (empty) begin
                  status_in = pida_pkg::ST_EMPTY;
               end else if (pos_ext >= cnt_ext) begin
                  status_in = pida_pkg::ST_BADPOS;
               end else begin
                  del_en   = 1'b1;
                  data_in  = rd_word;
                  count_in = count_ff - CW'(1);
               end
            end
            default: begin
            end
         endcase
         if (ins_en) begin
            count_in = count_ff + CW'(1);
         end
      end else if (cmd.disp_step) begin
         data_in = rd_word;
         last_in = stat.step_last;
         idx_in  = idx_ff + IW'(1);
      end
   end

   // Shift the whole row in one step: up for insert/append, down for delete
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         entries_in[k] = entries_ff[k];
         if (ins_en) begin
            if (CMPW'(k) == ins_pos) begin
               entries_in[k] = value;
            end else if (CMPW'(k) > ins_pos) begin
               entries_in[k] = entries_ff[(k > 0) ? k - 1 : 0];
            end
         end else if (del_en) begin
            if ((CMPW'(k) >= pos_ext) && (k + 1 < DEPTH)) begin
               entries_in[k] = entries_ff[(k + 1 < DEPTH) ? k + 1 : k];
            end
         end
      end
   end

   assign cnt_out_in = pida_pkg::CNT_OUT_W'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (cmd.exec || cmd.disp_step) begin
         data_ff    <= data_in;
         status_ff  <= status_in;
         cnt_out_ff <= cnt_out_in;
         last_ff    <= last_in;
      end
   end

   assign data_out    = data_ff;
   assign status      = status_ff;
   assign count_after = cnt_out_ff;
   assign last        = last_ff;

endmodule

// ===== hdl/pida_ctrl.sv =====
// Controller: request acceptance, display sequencing and response valid.
// Depends on pida_pkg; commands pida_dp through cmd_type.
module pida_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [pida_pkg::OP_W-1:0]  operation,
   input  logic                       rsp_ready,
   input  pida_pkg::stat_type         stat,
   output logic                       req_ready,
   output logic                       rsp_valid,
   output pida_pkg::cmd_type          cmd
);

   typedef enum logic {
      S_IDLE,
      S_DISPLAY
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free     = !rsp_valid_ff || rsp_ready;
   assign req_ready     = (state_ff == S_IDLE) && slot_free;
   assign cmd.exec      = req_valid && req_ready;
   assign cmd.disp_step = (state_ff == S_DISPLAY) && slot_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.exec && (operation == pida_pkg::OP_DISPLAY) && stat.multi) begin
               state_in = S_DISPLAY;
            end
         end
         S_DISPLAY: begin
            if (cmd.disp_step && stat.step_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (cmd.exec || cmd.disp_step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/positional_insert_delete_array.sv =====
// Positional insert/delete list: an ordered list of up to DEPTH signed 32-bit words.
//
// Channels: req_bus carries one operation per beat (clear, append, display, insert at
// position, delete at position). rsp_bus returns result beats with the word (display or
// delete), a status (ok, full, bad position, empty), the count after the operation, and
// last on the final beat of a request.
// Results: the first result beat is registered and shows in the cycle after the request
// beat. Clear, append, insert and delete each give one beat: the whole register row
// shifts when the request is taken. A display of N words streams N beats, one per cycle
// while rsp_bus is ready, through the single row read port; no request is taken until
// its last beat is loaded. An empty display gives one beat with empty status.
// Throughput: one request per cycle for single-beat operations while rsp_bus is ready,
// since a new request is taken in the cycle the waiting result is taken.
// Reset (synchronous, active high): count, display state and rsp valid clear; stored
// words are not cleared and are never read before being written.
// Stall: while a beat waits and rsp_bus is not ready, the result register holds it,
// req_ready drops, and display streaming pauses in place.
// Depends on pida_pkg, pida_if, pida_ctrl and pida_dp.
module positional_insert_delete_array #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   pida_req_if.sink    req_bus,
   pida_rsp_if.source  rsp_bus
);

   pida_pkg::cmd_type  cmd;
   pida_pkg::stat_type stat;

   // Sequence acceptance and display beats
   pida_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .operation (req_bus.operation),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .cmd       (cmd)
   );

   // Hold the list and build each result beat
   pida_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .operation   (req_bus.operation),
      .position    (req_bus.position),
      .value       (req_bus.value),
      .stat        (stat),
      .data_out    (rsp_bus.data_out),
      .status      (rsp_bus.status),
      .count_after (rsp_bus.count_after),
      .last        (rsp_bus.last)
   );

endmodule

// ===== hdl/pida_checker.sv =====
// Port-level checker for the positional insert/delete list, with its bind.
// Depends on pida_pkg and positional_insert_delete_array_assert.svh.
`include "positional_insert_delete_array_assert.svh"

module pida_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [pida_pkg::WORD_W-1:0]  rsp_data_out,
   input logic [pida_pkg::STATUS_W-1:0]       rsp_status,
   input logic [pida_pkg::CNT_OUT_W-1:0]      rsp_count_after,
   input logic                                rsp_last
);

   // A stalled beat holds
   `PIDA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data_out) && $stable(rsp_status) && $stable(rsp_last), "response beat changed while stalled")

   // Only display beats are non-final, and they are always ok
   `PIDA_ASSERT_IMP(a_mid_ok, rsp_valid && !rsp_last, rsp_status == pida_pkg::ST_OK, "non-final beat with error status")

   // No new request while a display is still streaming
   `PIDA_ASSERT_IMP(a_no_overlap, rsp_valid && !rsp_last, !(req_valid && req_ready), "request taken during display")

   // Empty status means an empty list and no word
   `PIDA_ASSERT_IMP(a_empty, rsp_valid && (rsp_status == pida_pkg::ST_EMPTY), (rsp_count_after == '0) && (rsp_data_out == '0) && rsp_last, "empty status with data")

endmodule

bind positional_insert_delete_array pida_checker u_pida_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_data_out    (rsp_bus.data_out),
   .rsp_status      (rsp_bus.status),
   .rsp_count_after (rsp_bus.count_after),
   .rsp_last        (rsp_bus.last)
);
